// File: rtl/mfbc_pkg.sv
// Package for the frame builder: queue command type, type tables and CRC fold.
`default_nettype none
package mfbc_pkg;

	localparam int PREAMBLE_LEN_DEF = 4;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// message type codes
	localparam logic [1:0] TYPE_CONTROL   = 2'd0;
	localparam logic [1:0] TYPE_SIGNAL    = 2'd1;
	localparam logic [1:0] TYPE_AUTOPILOT = 2'd2;
	localparam logic [1:0] TYPE_UNKNOWN   = 2'd3;

	// func codes
	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_PAYLOAD = 1'b1;

	// command handed from front to back
	typedef struct packed {
		logic        is_start;  // preamble run, else one payload byte
		logic [7:0]  data;      // marker or payload byte
		logic        crc_tail;  // CRC bytes follow
		logic [15:0] crc;       // CRC to send when crc_tail is set
	} cmd_t;

	function automatic logic [7:0] marker_of(input logic [1:0] t);
		logic [7:0] m;
		case (t)
			TYPE_CONTROL:   m = 8'h24;
			TYPE_SIGNAL:    m = 8'h25;
			TYPE_AUTOPILOT: m = 8'h5E;
			default:        m = 8'h61;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] length_of(input logic [1:0] t);
		logic [5:0] n;
		case (t)
			TYPE_CONTROL:   n = 6'd48;
			TYPE_SIGNAL:    n = 6'd8;
			TYPE_AUTOPILOT: n = 6'd32;
			default:        n = 6'd0;
		endcase
		return n;
	endfunction

	// shift-based CRC-16, polynomial 0x1021, one byte
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[7:0], crc[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/mfbc_queue.sv
// Short command queue between front and back.
`default_nettype none
module mfbc_queue #(
	parameter int DEPTH = mfbc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mfbc_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output mfbc_pkg::cmd_t     pop_data,
	output logic               not_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mfbc_pkg::cmd_t entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_ptrs_equal_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("queue pointers disagree");

endmodule
`default_nettype wire

// File: rtl/mfbc_front.sv
// Front end: accepts items, keeps frame state and CRC, issues commands.
`default_nettype none
module mfbc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          func,
	input  wire logic [1:0]    msg_type,
	input  wire logic [7:0]    payload_byte,
	output logic               push,
	output mfbc_pkg::cmd_t     push_data,
	input  wire logic          q_full
);
	logic        in_frame_q;
	logic [5:0]  bytes_left_q;
	logic [15:0] crc_q;
	logic        accept;
	logic [15:0] crc_next;
	logic [5:0]  len_start;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign crc_next  = mfbc_pkg::crc_fold(crc_q, payload_byte);
	assign len_start = mfbc_pkg::length_of(msg_type);

	// classify the item into a command
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			if (func == mfbc_pkg::FUNC_START) begin
				push               = 1'b1;
				push_data.is_start = 1'b1;
				push_data.data     = mfbc_pkg::marker_of(msg_type);
				push_data.crc_tail = (len_start == '0);
				push_data.crc      = '0;
			end else if (in_frame_q) begin
				push               = 1'b1;
				push_data.is_start = 1'b0;
				push_data.data     = payload_byte;
				push_data.crc_tail = (bytes_left_q == 6'd1);
				push_data.crc      = crc_next;
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
			crc_q        <= '0;
		end else if (accept) begin
			if (func == mfbc_pkg::FUNC_START) begin
				crc_q        <= '0;
				bytes_left_q <= len_start;
				in_frame_q   <= (len_start != '0);
			end else if (in_frame_q) begin
				crc_q        <= crc_next;
				bytes_left_q <= bytes_left_q - 1'b1;
				if (bytes_left_q == 6'd1) in_frame_q <= 1'b0;
			end
		end
	end

	a_open_frame_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (bytes_left_q != '0)) else $error("open frame with no bytes left");

endmodule
`default_nettype wire

// File: rtl/mfbc_back.sv
// Back end: expands commands into output bytes through an output register.
`default_nettype none
module mfbc_back #(
	parameter int PREAMBLE_LEN = mfbc_pkg::PREAMBLE_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_not_empty,
	input  wire mfbc_pkg::cmd_t q_data,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               frame_end
);
	localparam int IW = $clog2(PREAMBLE_LEN + 2);

	mfbc_pkg::cmd_t cur_q;
	logic           cur_valid_q;
	logic [IW-1:0]  idx_q;
	logic           out_valid_q;
	logic [7:0]     byte_q;
	logic           last_q, fend_q;

	logic [IW-1:0]  head_len;
	logic           is_lo, is_hi, last_now, advance;
	logic [7:0]     byte_now;

	// select the byte at the current position
	always_comb begin
		head_len = cur_q.is_start ? IW'(PREAMBLE_LEN) : IW'(1);
		is_lo    = (idx_q == head_len);
		is_hi    = (idx_q == head_len + 1'b1);
		if (is_hi)
			byte_now = cur_q.crc[15:8];
		else if (is_lo)
			byte_now = cur_q.crc[7:0];
		else if (cur_q.is_start && idx_q == IW'(PREAMBLE_LEN - 1))
			byte_now = 8'h00;
		else
			byte_now = cur_q.data;
		last_now = cur_q.crc_tail ? is_hi : (idx_q == head_len - 1'b1);
	end

	assign advance = cur_valid_q && (!out_valid_q || !out_stall);
	assign pop     = q_not_empty && (!cur_valid_q || (advance && last_now));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (advance) begin
			if (last_now) cur_valid_q <= 1'b0;
			else          idx_q       <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_data;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         out_valid_q <= 1'b0;
		else if (advance)    out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_now;
			last_q <= last_now;
			fend_q <= is_hi;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign run_last  = last_q;
	assign frame_end = fend_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fend_q) |-> last_q) else $error("frame end without run end");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= head_len + 1'b1)) else $error("sequencer index overrun");

endmodule
`default_nettype wire

// File: rtl/message_frame_builder_crc16.sv
// Path: item -> command queue -> back-end sequencer -> output register.
// Throughput: one byte per cycle while out_stall is low; a start item gives
// PREAMBLE_LEN bytes (+2 CRC if zero-length), a payload byte 1 (+2 if last).
// The back-end sequencer sets the rate; a 4-entry command queue absorbs bursts.
// Reset: asynchronous, clears frame state, CRC, queue and output valid; no sweep.
// Top level: frame builder with CRC-16, front, queue and back.
`default_nettype none
module message_frame_builder_crc16 #(
	parameter int PREAMBLE_LEN = mfbc_pkg::PREAMBLE_LEN_DEF,
	parameter int QUEUE_DEPTH  = mfbc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       func,
	input  wire logic [1:0] msg_type,
	input  wire logic [7:0] payload_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_end
);
	logic           push, q_full, pop, q_not_empty;
	mfbc_pkg::cmd_t push_data, q_data;

	mfbc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .msg_type, .payload_byte,
		.push, .push_data, .q_full
	);

	mfbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .pop_data(q_data), .not_empty(q_not_empty)
	);

	mfbc_back #(.PREAMBLE_LEN(PREAMBLE_LEN)) u_back (
		.clk, .arst_n, .q_not_empty, .q_data, .pop,
		.out_valid, .out_stall, .out_byte, .run_last, .frame_end
	);

endmodule
`default_nettype wire
